@@ design/nocd_pkg.sv @@
// package: widths, register indexes and arithmetic helpers for the clearance core
package nocd_pkg;
	localparam int GridWidthDef  = 64;
	localparam int GridHeightDef = 64;
	localparam int StoreDepth    = 4096;
	localparam int AddrW         = 12;
	localparam int CfgIdxW       = 3;
	localparam int ThresholdLimit = 100;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ORIGIN_X  = 3'd0,
		REG_ORIGIN_Y  = 3'd1,
		REG_YAW_COS   = 3'd2,
		REG_YAW_SIN   = 3'd3,
		REG_CELL_SIZE = 3'd4,
		REG_THRESHOLD = 3'd5,
		REG_GRID_VALID = 3'd6
	} reg_idx_t;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [11:0]        cell_index;
		logic signed [7:0]  occ_value;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic [30:0]        max_distance;
	} in_item_t;

	typedef struct packed {
		logic [30:0] clearance;
	} out_item_t;

	typedef struct packed {
		logic [CfgIdxW-1:0] index;
		logic [31:0]        data;
	} cfg_item_t;

	// magnitude of a 2^-31 unit value rounded half away to q16.16, saturated at 2^31
	function automatic logic [31:0] round_mag(input logic signed [63:0] d);
		logic [63:0] m;
		logic [63:0] q;
		begin
			m = d[63] ? 64'(-d) : 64'(d);
			q = (m + 64'd16384) >> 15;
			round_mag = (q > 64'h8000_0000) ? 32'h8000_0000 : q[31:0];
		end
	endfunction
endpackage

@@ design/nocd_if.sv @@
// valid/ready channel interfaces for items and configuration writes
interface nocd_in_if import nocd_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface nocd_out_if import nocd_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface nocd_cfg_if import nocd_pkg::*; ();
	logic      valid;
	logic      ready;
	cfg_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ design/nocd_isqrt.sv @@
// iterative 64-bit integer square root, one result bit per cycle
module nocd_isqrt import nocd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);
	logic [63:0] n_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic        busy_q;

	assign root = r_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (bit_q == 64'd0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= radicand;
			r_q   <= 64'd0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q && bit_q != 64'd0) begin
			if (n_q >= r_q + bit_q) begin
				n_q <= n_q - (r_q + bit_q);
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule

@@ design/nearest_occupied_cell_distance_core.sv @@
// top level: occupancy grid store, scan pipeline and clearance result
// A write item stores one cell in the 4096-entry occupancy memory.
// A query streams all GRID_WIDTH*GRID_HEIGHT cells out of that memory, one address per
// cycle, through a six-stage distance pipeline (memory read with cell offsets, rotation
// products, sum, rounding, squares, minimum), then runs a 32-step square root. A query on
// an invalid grid, a zero cell size or a threshold above 100 answers the cycle after its
// transfer. The result sits in an output register and no new item is taken until it has
// been transferred. Cells must be written before any query reads them.
module nearest_occupied_cell_distance_core import nocd_pkg::*; #(
	parameter int GRID_WIDTH  = GridWidthDef,
	parameter int GRID_HEIGHT = GridHeightDef
) (
	input logic       clk,
	input logic       arst_n,
	nocd_in_if.sink   items,
	nocd_out_if.source results,
	nocd_cfg_if.sink  cfg
);
	localparam int XW = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
	localparam int YW = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
	localparam int PipeDepth = 6;

	typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_ROOT, ST_WAIT} state_t;

	logic signed [31:0] origin_x_q, origin_y_q;
	logic signed [15:0] cos_q, sin_q;
	logic [30:0]        cell_size_q;
	logic [6:0]         thr_q;
	logic               grid_valid_q;

	logic signed [7:0]  mem [StoreDepth];

	state_t             state_q;
	logic [XW-1:0]      x_q;
	logic [YW-1:0]      y_q;
	logic               last_q;
	logic [3:0]         drain_q;
	logic signed [63:0] base_x_q, base_y_q;
	logic [30:0]        cap_q;
	logic [63:0]        least_q;
	logic               out_valid_q;
	logic [30:0]        out_q;

	// pipeline
	logic               v_s1;
	logic signed [63:0] lx_s1, ly_s1;
	logic signed [7:0]  cell_s1;
	logic               v_s2;
	logic signed [63:0] cx_s2, sy_s2, sx_s2, cy_s2;
	logic               v_s3;
	logic signed [63:0] dx_s3, dy_s3;
	logic               v_s4;
	logic [31:0]        mx_s4, my_s4;
	logic               v_s5;
	logic [63:0]        sq_s5;

	logic        sq_start, sq_done;
	logic [31:0] sq_root;

	logic in_fire, cfg_fire;
	assign items.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign in_fire     = items.valid && items.ready;
	assign cfg.ready   = 1'b1;
	assign cfg_fire    = cfg.valid;
	assign results.valid = out_valid_q;
	assign results.data.clearance = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			cos_q        <= 16'sd16384;
			sin_q        <= '0;
			cell_size_q  <= 31'd65536;
			thr_q        <= 7'd50;
			grid_valid_q <= 1'b0;
		end else if (cfg_fire) begin
			case (cfg.data.index)
				REG_ORIGIN_X:   origin_x_q   <= cfg.data.data;
				REG_ORIGIN_Y:   origin_y_q   <= cfg.data.data;
				REG_YAW_COS:    cos_q        <= cfg.data.data[15:0];
				REG_YAW_SIN:    sin_q        <= cfg.data.data[15:0];
				REG_CELL_SIZE:  cell_size_q  <= cfg.data.data[30:0];
				REG_THRESHOLD:  thr_q        <= cfg.data.data[6:0];
				REG_GRID_VALID: grid_valid_q <= cfg.data.data[0];
				default: ;
			endcase
		end
	end

	// scan address and store write
	logic [AddrW-1:0] scan_addr;
	assign scan_addr = AddrW'((32'(y_q) * 32'(GRID_WIDTH)) + 32'(x_q));

	always_ff @(posedge clk) begin
		if (in_fire && items.data.kind == KIND_WRITE) begin
			mem[items.data.cell_index] <= items.data.occ_value;
		end
		cell_s1 <= mem[scan_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			x_q         <= '0;
			y_q         <= '0;
			last_q      <= 1'b0;
			drain_q     <= '0;
			out_valid_q <= 1'b0;
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
		end else begin
			if (results.valid && results.ready) out_valid_q <= 1'b0;
			v_s1 <= (state_q == ST_SCAN);
			v_s2 <= v_s1 && (cell_s1 < 0 || cell_s1 >= $signed({2'b00, thr_q}));
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			case (state_q)
				ST_IDLE: begin
					if (in_fire && items.data.kind == KIND_QUERY) begin
						if (!grid_valid_q || cell_size_q == '0 || thr_q > 7'(ThresholdLimit)) begin
							out_valid_q <= 1'b1;
						end else begin
							state_q <= ST_SCAN;
							x_q     <= '0;
							y_q     <= '0;
							last_q  <= (GRID_WIDTH == 1) && (GRID_HEIGHT == 1);
						end
					end
				end
				ST_SCAN: begin
					if (last_q) begin
						state_q <= ST_DRAIN;
						drain_q <= 4'(PipeDepth);
					end else begin
						if (32'(x_q) == 32'(GRID_WIDTH - 1)) begin
							x_q <= '0;
							y_q <= y_q + 1'b1;
							last_q <= (32'(y_q) == 32'(GRID_HEIGHT - 2)) && (GRID_WIDTH == 1);
						end else begin
							x_q <= x_q + 1'b1;
							last_q <= (32'(y_q) == 32'(GRID_HEIGHT - 1))
								&& (32'(x_q) == 32'(GRID_WIDTH - 2));
						end
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q - 1'b1;
					if (drain_q == 4'd1) state_q <= ST_ROOT;
				end
				ST_ROOT: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (sq_done) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign sq_start = (state_q == ST_ROOT);

	always_ff @(posedge clk) begin
		if (in_fire && items.data.kind == KIND_QUERY) begin
			base_x_q <= (64'(origin_x_q) - 64'(items.data.point_x)) <<< 15;
			base_y_q <= (64'(origin_y_q) - 64'(items.data.point_y)) <<< 15;
			cap_q    <= items.data.max_distance;
			least_q  <= 64'(items.data.max_distance) * 64'(items.data.max_distance);
			out_q    <= '0;
		end
		// stage 1: cell center offsets (2x+1)*cell_size in 2^-17 m
		lx_s1 <= $signed(64'({x_q, 1'b1}) * 64'(cell_size_q));
		ly_s1 <= $signed(64'({y_q, 1'b1}) * 64'(cell_size_q));
		// stage 2: rotation products, 16 by 38 bits at the default 64 by 64 grid
		cx_s2 <= 64'(cos_q) * lx_s1;
		sx_s2 <= 64'(sin_q) * lx_s1;
		sy_s2 <= 64'(sin_q) * ly_s1;
		cy_s2 <= 64'(cos_q) * ly_s1;
		dx_s3 <= base_x_q + cx_s2 - sy_s2;
		dy_s3 <= base_y_q + sx_s2 + cy_s2;
		mx_s4 <= round_mag(dx_s3);
		my_s4 <= round_mag(dy_s3);
		sq_s5 <= 64'(mx_s4) * 64'(mx_s4) + 64'(my_s4) * 64'(my_s4);
		if (v_s5 && sq_s5 < least_q) least_q <= sq_s5;
		if (sq_done) out_q <= (sq_root > 32'(cap_q)) ? cap_q : sq_root[30:0];
	end

	nocd_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (least_q),
		.done     (sq_done),
		.root     (sq_root)
	);
endmodule
